FILE: rtl/fdmb_pkg.sv
// Shared constants and types for the frame difference motion box.
package fdmb_pkg;

  // Largest frame the pixel store holds
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Position counter and store address widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;

  // Width of a clamped frame side (holds MAX itself)
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);

  // Field widths
  localparam int PIX_W   = 8;
  localparam int SIDE_W  = 11;
  localparam int THR_W   = 8;
  localparam int CNT_W   = 21;
  localparam int POS_W   = 10;
  localparam int SIZE_W  = 11;
  localparam int CFG_W   = 21;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] TALLY_MAX = {CNT_W{1'b1}};

  // Register reset values
  localparam logic [SIDE_W-1:0] FRAME_WIDTH_RST  = SIDE_W'(640);
  localparam logic [SIDE_W-1:0] FRAME_HEIGHT_RST = SIDE_W'(480);
  localparam logic [THR_W-1:0]  DIFF_THR_RST     = THR_W'(25);
  localparam logic [CNT_W-1:0]  COUNT_LIMIT_RST  = CNT_W'(5000);
  localparam logic [SIDE_W-1:0] MIN_SIDE_RST     = SIDE_W'(20);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_DIFF_THR     = 3'd2,
    REG_COUNT_LIMIT  = 3'd3,
    REG_MIN_SIDE     = 3'd4
  } cfg_reg_t;

  // Pixel held in the compare stage while it is compared with the stored pixel from the same place
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
    logic             have_prev;
  } stage_t;

endpackage

FILE: rtl/frame_difference_motion_box.sv
// Frame difference motion detector with bounding box, top level.
//
// Grey pixels enter in raster order on the in_ valid/ready channel, one per
// transfer. Each pixel is compared with the pixel at the same place in the
// previous frame, held in an on-chip store, and then replaces it. The last
// pixel of a frame yields one result transfer on the out_ channel: bounding
// box, moving pixel count and the frame_moving, region_large, no_motion and
// first_frame flags. Other pixels yield nothing.
// Throughput: one pixel per cycle while no frame end waits on a held result.
// The result is registered: the last pixel of the frame goes into the store read
// and pixel register, then into the result register.
// The store read port sets the pixel register stage; the store is read and
// written once per pixel at the same address.
// While a result waits on out_ready, pixels keep flowing; only the next frame
// end stalls the input until the waiting result is taken.
// Reset (rst_n low, synchronous) loads register defaults, empties the pipe and
// forgets the previous frame: the next frame reports the whole frame moving.
// Register writes on cfg_ take effect at once; write them between pixels only.
module frame_difference_motion_box (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [fdmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdmb_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fdmb_pkg::PIX_W-1:0] in_pixel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fdmb_pkg::POS_W-1:0] out_box_x,
  output logic [fdmb_pkg::POS_W-1:0] out_box_y,
  output logic [fdmb_pkg::SIZE_W-1:0] out_box_width,
  output logic [fdmb_pkg::SIZE_W-1:0] out_box_height,
  output logic [fdmb_pkg::CNT_W-1:0] out_moving_count,
  output logic                       out_frame_moving,
  output logic                       out_region_large,
  output logic                       out_no_motion,
  output logic                       out_first_frame
);
  import fdmb_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  // Configuration registers
  logic [SIDE_W-1:0] frame_width_r, frame_height_r, min_side_r;
  logic [THR_W-1:0]  diff_thr_r;
  logic [CNT_W-1:0]  count_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      diff_thr_r     <= DIFF_THR_RST;
      count_limit_r  <= COUNT_LIMIT_RST;
      min_side_r     <= MIN_SIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[SIDE_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[SIDE_W-1:0];
        REG_DIFF_THR:     diff_thr_r     <= cfg_wdata[THR_W-1:0];
        REG_COUNT_LIMIT:  count_limit_r  <= cfg_wdata[CNT_W-1:0];
        REG_MIN_SIDE:     min_side_r     <= cfg_wdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame sides to 1..MAX
  logic [WEFF_W-1:0] w_eff;
  logic [HEFF_W-1:0] h_eff;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = HEFF_W'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(frame_height_r);
    end
  end

  // Handshake and pipe control
  stage_t s1_r;
  logic   s1_valid_r;
  logic   out_valid_r;
  logic   s1_go;
  logic   in_xfer;

  assign s1_go    = s1_valid_r && !(s1_r.frame_end && out_valid_r && !out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_xfer  = in_valid && in_ready;

  // Raster position counters and first-frame marker
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic             have_prev_r;
  logic             last_col, last_row;

  assign last_col = (32'(col_cnt_r) + 1) >= 32'(w_eff);
  assign last_row = (32'(row_cnt_r) + 1) >= 32'(h_eff);

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = last_row ? '0 : row_cnt_r + ROW_W'(1);
    end else begin
      col_cnt_nxt = col_cnt_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      have_prev_r <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
        if (last_col && last_row) begin
          have_prev_r <= 1'b1;
        end
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.col       <= col_cnt_r;
      s1_r.row       <= row_cnt_r;
      s1_r.pixel     <= in_pixel;
      s1_r.frame_end <= last_col && last_row;
      s1_r.have_prev <= have_prev_r;
    end
  end

  // Previous frame store: read old value and write new pixel in the same cycle
  logic [PIX_W-1:0]  prev_mem [DEPTH];
  logic [PIX_W-1:0]  prev_rd_r;
  logic [ADDR_W-1:0] addr;

  assign addr = {row_cnt_r, col_cnt_r};

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      prev_mem[addr] <= in_pixel;
      prev_rd_r      <= prev_mem[addr];
    end
  end

  // Difference test
  logic [PIX_W-1:0] diff;
  logic             hit;

  assign diff = (s1_r.pixel > prev_rd_r) ? s1_r.pixel - prev_rd_r : prev_rd_r - s1_r.pixel;
  assign hit  = s1_r.have_prev && (diff > diff_thr_r);

  // Per-frame statistics
  logic [COL_W-1:0] least_col_r, least_col_nxt, great_col_r, great_col_nxt;
  logic [ROW_W-1:0] least_row_r, least_row_nxt, great_row_r, great_row_nxt;
  logic [CNT_W-1:0] tally_r, tally_nxt;
  logic             any_hit_r, any_hit_nxt;

  always_comb begin
    least_col_nxt = least_col_r;
    great_col_nxt = great_col_r;
    least_row_nxt = least_row_r;
    great_row_nxt = great_row_r;
    tally_nxt     = tally_r;
    any_hit_nxt   = any_hit_r;
    if (hit) begin
      if (tally_r != TALLY_MAX) begin
        tally_nxt = tally_r + CNT_W'(1);
      end
      any_hit_nxt = 1'b1;
      if (!any_hit_r) begin
        least_col_nxt = s1_r.col;
        great_col_nxt = s1_r.col;
        least_row_nxt = s1_r.row;
        great_row_nxt = s1_r.row;
      end else begin
        if (s1_r.col < least_col_r) least_col_nxt = s1_r.col;
        if (s1_r.col > great_col_r) great_col_nxt = s1_r.col;
        if (s1_r.row < least_row_r) least_row_nxt = s1_r.row;
        if (s1_r.row > great_row_r) great_row_nxt = s1_r.row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      least_col_r <= '1;
      least_row_r <= '1;
      great_col_r <= '0;
      great_row_r <= '0;
      tally_r     <= '0;
      any_hit_r   <= 1'b0;
    end else if (s1_go) begin
      if (s1_r.frame_end) begin
        least_col_r <= '1;
        least_row_r <= '1;
        great_col_r <= '0;
        great_row_r <= '0;
        tally_r     <= '0;
        any_hit_r   <= 1'b0;
      end else begin
        least_col_r <= least_col_nxt;
        least_row_r <= least_row_nxt;
        great_col_r <= great_col_nxt;
        great_row_r <= great_row_nxt;
        tally_r     <= tally_nxt;
        any_hit_r   <= any_hit_nxt;
      end
    end
  end

  // Frame result
  logic [COL_W-1:0]  span_col;
  logic [ROW_W-1:0]  span_row;
  logic [POS_W-1:0]  res_x, res_y;
  logic [SIZE_W-1:0] res_w, res_h;
  logic [CNT_W-1:0]  res_cnt;
  logic              res_moving, res_large, res_none;

  assign span_col = great_col_nxt - least_col_nxt;
  assign span_row = great_row_nxt - least_row_nxt;

  always_comb begin
    res_x      = '0;
    res_y      = '0;
    res_w      = '0;
    res_h      = '0;
    res_cnt    = '0;
    res_moving = 1'b1;
    res_large  = 1'b0;
    res_none   = 1'b0;
    if (!s1_r.have_prev) begin
      res_w     = SIZE_W'(w_eff);
      res_h     = SIZE_W'(h_eff);
      res_large = (32'(w_eff) >= 32'(min_side_r)) && (32'(h_eff) >= 32'(min_side_r));
    end else begin
      res_cnt    = tally_nxt;
      res_moving = tally_nxt > count_limit_r;
      if (any_hit_nxt) begin
        res_x     = POS_W'(least_col_nxt);
        res_y     = POS_W'(least_row_nxt);
        res_w     = SIZE_W'(span_col);
        res_h     = SIZE_W'(span_row);
        res_large = (32'(span_col) >= 32'(min_side_r)) &&
                    (32'(span_row) >= 32'(min_side_r));
      end else begin
        res_none = 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_r.frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_r.frame_end) begin
      out_box_x        <= res_x;
      out_box_y        <= res_y;
      out_box_width    <= res_w;
      out_box_height   <= res_h;
      out_moving_count <= res_cnt;
      out_frame_moving <= res_moving;
      out_region_large <= res_large;
      out_no_motion    <= res_none;
      out_first_frame  <= !s1_r.have_prev;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/fdmb_checker.sv
// Port-level assertions for the frame difference motion box, with bind.
module fdmb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fdmb_pkg::POS_W-1:0]  out_box_x,
  input logic [fdmb_pkg::POS_W-1:0]  out_box_y,
  input logic [fdmb_pkg::SIZE_W-1:0] out_box_width,
  input logic [fdmb_pkg::SIZE_W-1:0] out_box_height,
  input logic [fdmb_pkg::CNT_W-1:0]  out_moving_count,
  input logic                        out_frame_moving,
  input logic                        out_region_large,
  input logic                        out_no_motion,
  input logic                        out_first_frame
);
  import fdmb_pkg::*;

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_moving_count) &&
    $stable(out_box_x) && $stable(out_box_width) && $stable(out_no_motion))
    else $error("stalled result changed");

  // Quiet frame reports an empty box
  a_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_motion |-> out_box_x == '0 && out_box_y == '0 &&
    out_box_width == '0 && out_box_height == '0 && out_moving_count == '0 &&
    !out_region_large && !out_first_frame)
    else $error("no_motion result with nonempty box");

  // First frame reports full motion and no count
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_frame |-> out_frame_moving && !out_no_motion &&
    out_moving_count == '0 && out_box_x == '0 && out_box_y == '0)
    else $error("bad first frame result");

  // Any counted pixel means motion was seen
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moving_count != '0 |-> !out_no_motion)
    else $error("count without motion");

endmodule

bind frame_difference_motion_box fdmb_checker u_fdmb_checker (.*);

FILE: verif/tb.sv
// Testbench for frame_difference_motion_box: raster-order pixel stimulus, per-frame box check.
`timescale 1ns / 100ps

module tb;
  import fdmb_pkg::*;

  // Result of one frame, field for field as on the out_ channel
  typedef struct packed {
    logic [POS_W-1:0]  box_x;
    logic [POS_W-1:0]  box_y;
    logic [SIZE_W-1:0] box_width;
    logic [SIZE_W-1:0] box_height;
    logic [CNT_W-1:0]  moving_count;
    logic              frame_moving;
    logic              region_large;
    logic              no_motion;
    logic              first_frame;
  } motion_box_t;

  // Pixel content styles for one frame
  typedef enum int {SCENE_STILL, SCENE_BLOB, SCENE_RANDOM, SCENE_DARK, SCENE_BRIGHT} scene_t;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 3'd7;

  // Shadow of the detector: registers, previous frame store and per-frame tracking
  class motion_scoreboard;
    bit [PIX_W-1:0] scene [MAX_WIDTH*MAX_HEIGHT];
    int unsigned width_reg, height_reg, thr_reg, limit_reg, side_reg;
    bit          seen_frame;
    int unsigned col_cnt, row_cnt;
    int unsigned lo_col, lo_row, hi_col, hi_row, tally;
    bit          hit;
    motion_box_t pending_boxes[$];
    int unsigned mismatches;

    function new();
      width_reg  = 32'(FRAME_WIDTH_RST);
      height_reg = 32'(FRAME_HEIGHT_RST);
      thr_reg    = 32'(DIFF_THR_RST);
      limit_reg  = 32'(COUNT_LIMIT_RST);
      side_reg   = 32'(MIN_SIDE_RST);
      seen_frame = 1'b0;
      mismatches = 0;
      clear_tracking();
    endfunction

    function void clear_tracking();
      col_cnt = 0;
      row_cnt = 0;
      lo_col  = '1;
      lo_row  = '1;
      hi_col  = 0;
      hi_row  = 0;
      tally   = 0;
      hit     = 1'b0;
    endfunction

    function int unsigned fit_side(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:  width_reg  = 32'(data[SIDE_W-1:0]);
        REG_FRAME_HEIGHT: height_reg = 32'(data[SIDE_W-1:0]);
        REG_DIFF_THR:     thr_reg    = 32'(data[THR_W-1:0]);
        REG_COUNT_LIMIT:  limit_reg  = 32'(data[CNT_W-1:0]);
        REG_MIN_SIDE:     side_reg   = 32'(data[SIDE_W-1:0]);
        default: ;
      endcase
    endfunction

    // One accepted pixel: compare, update box, store, and close the frame on its last pixel
    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned w, h, col, row, addr, prev, d;
      motion_box_t r;
      w    = fit_side(width_reg, MAX_WIDTH);
      h    = fit_side(height_reg, MAX_HEIGHT);
      col  = (col_cnt < MAX_WIDTH) ? col_cnt : MAX_WIDTH - 1;
      row  = (row_cnt < MAX_HEIGHT) ? row_cnt : MAX_HEIGHT - 1;
      addr = row * MAX_WIDTH + col;
      if (seen_frame) begin
        prev = 32'(scene[addr]);
        d = (32'(px) > prev) ? 32'(px) - prev : prev - 32'(px);
        if (d > thr_reg) begin
          if (tally < TALLY_MAX) tally++;
          if (!hit) begin
            lo_col = col;
            hi_col = col;
            lo_row = row;
            hi_row = row;
            hit    = 1'b1;
          end else begin
            if (col < lo_col) lo_col = col;
            if (col > hi_col) hi_col = col;
            if (row < lo_row) lo_row = row;
            if (row > hi_row) hi_row = row;
          end
        end
      end
      scene[addr] = px;

      if (col_cnt + 1 < w) begin
        col_cnt++;
        return;
      end
      col_cnt = 0;
      if (row_cnt + 1 < h) begin
        row_cnt++;
        return;
      end

      r = '0;
      if (!seen_frame) begin
        // nothing to compare against yet: whole frame reported as moving
        r.box_width    = SIZE_W'(w);
        r.box_height   = SIZE_W'(h);
        r.frame_moving = 1'b1;
        r.first_frame  = 1'b1;
        r.region_large = (w >= side_reg) && (h >= side_reg);
      end else begin
        r.moving_count = CNT_W'(tally);
        r.frame_moving = tally > limit_reg;
        if (hit) begin
          r.box_x        = POS_W'(lo_col);
          r.box_y        = POS_W'(lo_row);
          r.box_width    = SIZE_W'(hi_col - lo_col);
          r.box_height   = SIZE_W'(hi_row - lo_row);
          r.region_large = ((hi_col - lo_col) >= side_reg) && ((hi_row - lo_row) >= side_reg);
        end else begin
          r.no_motion = 1'b1;
        end
      end
      pending_boxes.push_back(r);
      seen_frame = 1'b1;
      clear_tracking();
    endfunction

    function void match(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(motion_box_t seen);
      motion_box_t want;
      if (pending_boxes.size() == 0) begin
        $error("result transfer with no frame end pending");
        mismatches++;
        return;
      end
      want = pending_boxes.pop_front();
      match("box_x", 32'(want.box_x), 32'(seen.box_x));
      match("box_y", 32'(want.box_y), 32'(seen.box_y));
      match("box_width", 32'(want.box_width), 32'(seen.box_width));
      match("box_height", 32'(want.box_height), 32'(seen.box_height));
      match("moving_count", 32'(want.moving_count), 32'(seen.moving_count));
      match("frame_moving", 32'(want.frame_moving), 32'(seen.frame_moving));
      match("region_large", 32'(want.region_large), 32'(seen.region_large));
      match("no_motion", 32'(want.no_motion), 32'(seen.no_motion));
      match("first_frame", 32'(want.first_frame), 32'(seen.first_frame));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [POS_W-1:0]     out_box_x, out_box_y;
  logic [SIZE_W-1:0]    out_box_width, out_box_height;
  logic [CNT_W-1:0]     out_moving_count;
  logic                 out_frame_moving, out_region_large, out_no_motion, out_first_frame;

  motion_scoreboard sb = new();
  int unsigned      pixels_sent = 0;
  bit               send_calm = 1'b0;
  bit               squeeze_now = 1'b0;
  int unsigned      blob_x0, blob_x1, blob_y0, blob_y1;

  frame_difference_motion_box u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_box_x        (out_box_x),
    .out_box_y        (out_box_y),
    .out_box_width    (out_box_width),
    .out_box_height   (out_box_height),
    .out_moving_count (out_moving_count),
    .out_frame_moving (out_frame_moving),
    .out_region_large (out_region_large),
    .out_no_motion    (out_no_motion),
    .out_first_frame  (out_first_frame)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_side();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 16);
    return 0;  // clamps to one
  endfunction

  function automatic scene_t pick_scene();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return SCENE_STILL;
    if (r < 70) return SCENE_BLOB;
    if (r < 90) return SCENE_RANDOM;
    if (r < 95) return SCENE_DARK;
    return SCENE_BRIGHT;
  endfunction

  function automatic void place_blob();
    int unsigned w, h;
    w = sb.fit_side(sb.width_reg, MAX_WIDTH);
    h = sb.fit_side(sb.height_reg, MAX_HEIGHT);
    blob_x0 = $urandom_range(0, w - 1);
    blob_x1 = $urandom_range(blob_x0, w - 1);
    blob_y0 = $urandom_range(0, h - 1);
    blob_y1 = $urandom_range(blob_y0, h - 1);
  endfunction

  // Next pixel for the current raster position; stored pixel plus small noise is still
  function automatic logic [PIX_W-1:0] next_pixel(scene_t mode);
    int col, row, prev, v;
    col  = sb.col_cnt;
    row  = sb.row_cnt;
    prev = int'(sb.scene[row * MAX_WIDTH + col]);
    case (mode)
      SCENE_DARK:   return '0;
      SCENE_BRIGHT: return '1;
      SCENE_RANDOM: return PIX_W'($urandom_range(0, 255));
      default: ;
    endcase
    if (mode == SCENE_BLOB && col >= blob_x0 && col <= blob_x1 &&
        row >= blob_y0 && row <= blob_y1)
      return PIX_W'(prev + 128 + int'($urandom_range(0, 120)) - 60);
    v = prev - 3 + int'($urandom_range(0, 6));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  // One pixel transfer on in_
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  // n pixels, or up to the end of the frame when n is zero
  task automatic send_run(input int unsigned n, input scene_t mode);
    int unsigned left;
    left = n;
    do begin
      send_pixel(next_pixel(mode));
      if (left > 0) left--;
    end while ((n > 0) ? (left > 0) : (sb.col_cnt != 0 || sb.row_cnt != 0));
  endtask

  // Stop the input and let the pipe drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_boxes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic shuffle_config();
    int unsigned r;
    if ($urandom_range(0, 1)) write_reg(REG_FRAME_WIDTH, CFG_W'(pick_side()));
    if ($urandom_range(0, 1)) write_reg(REG_FRAME_HEIGHT, CFG_W'(pick_side()));
    if ($urandom_range(0, 1))
      write_reg(REG_DIFF_THR, CFG_W'(($urandom_range(0, 2) != 0) ? $urandom_range(0, 40)
                                                                 : $urandom_range(0, 255)));
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      if (r < 50)      write_reg(REG_COUNT_LIMIT, CFG_W'($urandom_range(0, 30)));
      else if (r < 75) write_reg(REG_COUNT_LIMIT, '0);
      else if (r < 90) write_reg(REG_COUNT_LIMIT, CFG_W'($urandom_range(0, 300)));
      else             write_reg(REG_COUNT_LIMIT, CFG_W'($urandom));
    end
    if ($urandom_range(0, 1))
      write_reg(REG_MIN_SIDE, CFG_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 8)
                                                                 : $urandom_range(0, 2047)));
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    bit          calm, squeezed;
    motion_box_t seen;
    calm     = 1'b0;
    squeezed = 1'b0;
    forever begin
      if (squeeze_now && !squeezed) begin
        squeezed = 1'b1;
        stall    = 400;
      end else begin
        stall = pick_gap(calm);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      seen.box_x        = out_box_x;
      seen.box_y        = out_box_y;
      seen.box_width    = out_box_width;
      seen.box_height   = out_box_height;
      seen.moving_count = out_moving_count;
      seen.frame_moving = out_frame_moving;
      seen.region_large = out_region_large;
      seen.no_motion    = out_no_motion;
      seen.first_frame  = out_first_frame;
      sb.check_result(seen);
      if ($urandom_range(0, 9) == 0) calm = !calm;
    end
  end

  // Stimulus
  initial begin : pixel_source
    int unsigned goal, w, h;
    scene_t      mode;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First frame seeds the store: all of row 0 at the clamped width, then a 16x16 corner
    write_reg(REG_FRAME_WIDTH, CFG_W'(2047));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2047));
    send_run(MAX_WIDTH, SCENE_RANDOM);
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(16));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(16));
    write_reg(REG_MIN_SIDE, CFG_W'(16));
    send_run(0, SCENE_RANDOM);
    settle();

    // Directed 2x2 frames: still, single moving pixel, threshold extremes
    write_reg(REG_FRAME_WIDTH, CFG_W'(2));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
    write_reg(REG_MIN_SIDE, '0);
    write_reg(REG_COUNT_LIMIT, '0);
    send_run(0, SCENE_STILL);
    blob_x0 = 1; blob_x1 = 1; blob_y0 = 1; blob_y1 = 1;
    send_run(0, SCENE_BLOB);
    settle();
    write_reg(REG_DIFF_THR, CFG_W'(255));
    send_run(0, SCENE_BRIGHT);
    settle();
    write_reg(REG_DIFF_THR, CFG_W'(254));
    write_reg(REG_MIN_SIDE, CFG_W'(2047));
    send_run(0, SCENE_DARK);
    settle();
    write_reg(REG_DIFF_THR, '0);
    write_reg(REG_COUNT_LIMIT, '1);
    send_run(0, SCENE_RANDOM);
    settle();

    // Size shrinks mid-frame, past the running column and then row counter
    write_reg(REG_FRAME_WIDTH, CFG_W'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
    write_reg(REG_COUNT_LIMIT, CFG_W'(1048576));
    write_reg(REG_DIFF_THR, CFG_W'(25));
    send_run(3, SCENE_RANDOM);
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(2));
    send_run(4, SCENE_RANDOM);
    settle();
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
    send_run(0, SCENE_RANDOM);
    settle();

    // Zero sides clamp to a single pixel frame; unmapped index has no effect
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    write_reg(IDX_SPARE, CFG_W'($urandom));
    send_run(0, SCENE_RANDOM);
    send_run(0, SCENE_DARK);
    settle();

    // Back-to-back 4x4 frames while the sink holds off, so a frame end stalls the input
    write_reg(REG_FRAME_WIDTH, CFG_W'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(4));
    write_reg(REG_MIN_SIDE, CFG_W'(2));
    squeeze_now = 1'b1;
    repeat (6) send_run(0, SCENE_RANDOM);

    // Random small frames up to the item budget
    goal = 1950;
    while (pixels_sent < goal) begin
      settle();
      shuffle_config();
      mode = pick_scene();
      place_blob();
      send_calm = ($urandom_range(0, 4) == 0);
      w = sb.fit_side(sb.width_reg, MAX_WIDTH);
      h = sb.fit_side(sb.height_reg, MAX_HEIGHT);
      if (w * h > 1 && $urandom_range(0, 19) == 0) begin
        // broken frame: new size part way through
        send_run($urandom_range(1, w * h - 1), mode);
        settle();
        if ($urandom_range(0, 1)) write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(1, 16)));
        else                      write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(1, 16)));
      end
      send_run(0, mode);
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
